// ===== hw/rtl/ssm_pkg.sv =====
// Shared types, constants and helpers for the stream substring matcher.
// No dependencies; used by ssm_cell and stream_substring_matcher.
`default_nettype none

package ssm_pkg;

  localparam int unsigned PAT_BYTES_MAX = 16;
  localparam int unsigned PAT_BITS      = 8 * PAT_BYTES_MAX;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  // per-cycle control handed to every history cell
  typedef struct packed {
    logic adv;   // an item is accepted
    logic clr;   // accepted item ends the stream
  } shift_ctl_t;

  function automatic logic [7:0] pat_byte(input logic [PAT_BITS-1:0] pat,
                                          input logic [3:0] idx);
    pat_byte = pat[idx*8 +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ssm_cell.sv =====
// One history cell: holds one past text byte, shifts it on, and compares it
// against the pattern byte that lines up with its position. Uses ssm_pkg.
`default_nettype none

module ssm_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ssm_pkg::shift_ctl_t           ctl,
  input  wire logic [7:0]                    byte_i,
  input  wire logic                          valid_i,
  input  wire logic [ssm_pkg::PAT_BITS-1:0]  pat,
  input  wire logic [ssm_pkg::LEN_W-1:0]     len,
  output logic [7:0]                         byte_o,
  output logic                               valid_o,
  output logic                               ok_o
);

  // cell IDX holds the byte IDX+1 back; it is used when len >= IDX+2
  localparam logic [ssm_pkg::LEN_W-1:0] NEED = ssm_pkg::LEN_W'(IDX + 2);

  logic [7:0]                byte_r;
  logic                      valid_r;
  logic [ssm_pkg::LEN_W-1:0] pidx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.adv) begin
      valid_r <= ctl.clr ? 1'b0 : valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      byte_r <= byte_i;
    end
  end

  assign pidx    = len - NEED;
  assign ok_o    = (len < NEED) ||
                   (valid_r && (byte_r == ssm_pkg::pat_byte(pat, pidx[3:0])));
  assign byte_o  = byte_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stream_substring_matcher.sv =====
// Stream substring matcher top level: config registers, history cell chain,
// match/holdoff/count control and output register. Uses ssm_pkg, ssm_cell.
//
// Usage:
//   in_*  : one text byte per item in in_tdata, in_tlast marks the final byte.
//   out_* : one result per input item. out_tdata = {match_total, match_start},
//           out_tuser = match_found, out_tlast = end of stream.
//   cfg_* : write pattern_low_bytes (0), pattern_high_bytes (1) and
//           pattern_length (2); other indexes are dropped. Write while idle.
// Latency: the result is registered and appears the cycle after acceptance.
// Throughput: one item per cycle while the output is not stalled. All window
// compares for a byte are done in parallel by the MAX_PATTERN-1 history cells
// plus the current byte. in_tready is high out of reset whenever the output
// register is empty or being drained, so a stalled receiver holds one result
// and then stops input. Reset clears history, offset, match count and holdoff,
// sets the pattern to zeros with length 1. After a last byte the stream state
// resets the same way; pattern registers are kept.
`default_nettype none

module stream_substring_matcher #(
  parameter int unsigned MAX_PATTERN = ssm_pkg::PAT_BYTES_MAX
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input items
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] text_byte
  input  wire logic                             in_tlast,
  // result items
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [63:0]                           out_tdata,  // [31:0] match_start,
                                                            // [63:32] match_total
  output logic                                  out_tuser,  // [0] match_found
  output logic                                  out_tlast,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned NCELL = MAX_PATTERN - 1;
  localparam logic [ssm_pkg::LEN_W-1:0] MAX_LEN = ssm_pkg::LEN_W'(MAX_PATTERN);

  logic [63:0]                 pat_low_r;
  logic [63:0]                 pat_high_r;
  logic [ssm_pkg::LEN_W-1:0]   pat_len_r;
  logic [ssm_pkg::PAT_BITS-1:0] pat;
  logic [ssm_pkg::LEN_W-1:0]   len;
  logic [ssm_pkg::LEN_W-1:0]   cur_idx;

  ssm_pkg::shift_ctl_t         ctl;
  logic                        accept;

  logic [7:0]                  hist_byte  [0:NCELL];
  logic                        hist_valid [0:NCELL];
  logic [NCELL:0]              ok_vec;

  logic                        window_eq;
  logic                        found;
  logic [ssm_pkg::CNT_W-1:0]   seen_r,    seen_nxt;
  logic [ssm_pkg::CNT_W-1:0]   total_r,   total_nxt;
  logic [ssm_pkg::LEN_W-1:0]   holdoff_r, holdoff_nxt;
  logic [ssm_pkg::CNT_W-1:0]   start;

  logic                        out_valid_r;
  logic                        found_r;
  logic [ssm_pkg::CNT_W-1:0]   start_r;
  logic [ssm_pkg::CNT_W-1:0]   res_total_r;
  logic                        done_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= ssm_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssm_pkg::REG_PAT_LOW:  pat_low_r  <= cfg_wdata;
        ssm_pkg::REG_PAT_HIGH: pat_high_r <= cfg_wdata;
        ssm_pkg::REG_PAT_LEN:  pat_len_r  <= cfg_wdata[ssm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat     = {pat_high_r, pat_low_r};
  assign len     = (pat_len_r > MAX_LEN) ? MAX_LEN : pat_len_r;
  assign cur_idx = len - ssm_pkg::LEN_W'(1);

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign ctl.adv   = accept;
  assign ctl.clr   = in_tlast;

  // history chain: entry k feeds cell k
  assign hist_byte[0]  = in_tdata;
  assign hist_valid[0] = 1'b1;
  assign ok_vec[0]     = (in_tdata == ssm_pkg::pat_byte(pat, cur_idx[3:0]));

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ssm_cell #(.IDX(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .byte_i  (hist_byte[k]),
      .valid_i (hist_valid[k]),
      .pat     (pat),
      .len     (len),
      .byte_o  (hist_byte[k+1]),
      .valid_o (hist_valid[k+1]),
      .ok_o    (ok_vec[k+1])
    );
  end

  assign window_eq = (len != '0) && (&ok_vec);

  always_comb begin
    found       = 1'b0;
    holdoff_nxt = holdoff_r;
    total_nxt   = total_r;
    start       = '0;
    if (holdoff_r != '0) begin
      holdoff_nxt = holdoff_r - ssm_pkg::LEN_W'(1);
    end else if (window_eq) begin
      found       = 1'b1;
      start       = seen_r - ssm_pkg::CNT_W'(cur_idx);
      holdoff_nxt = cur_idx;
      if (total_r != '1) begin
        total_nxt = total_r + ssm_pkg::CNT_W'(1);
      end
    end
    seen_nxt = seen_r + ssm_pkg::CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r    <= '0;
      total_r   <= '0;
      holdoff_r <= '0;
    end else if (accept) begin
      if (in_tlast) begin
        seen_r    <= '0;
        total_r   <= '0;
        holdoff_r <= '0;
      end else begin
        seen_r    <= seen_nxt;
        total_r   <= total_nxt;
        holdoff_r <= holdoff_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r     <= found;
      start_r     <= start;
      res_total_r <= total_nxt;
      done_r      <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_total_r, start_r};
  assign out_tuser  = found_r;
  assign out_tlast  = done_r;

endmodule

`default_nettype wire
